@@ hdl/rrts_pkg.sv @@
// Shared types and constants for the round-robin thread scheduler.
`default_nettype none

package rrts_pkg;

  localparam int ID_FIELD_W = 5;
  localparam int OP_W = 2;
  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_YIELD  = 2'd1,
    OP_EXIT   = 2'd2,
    OP_JOIN   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_UNKNOWN   = 2'd2,
    STAT_NO_ACTIVE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SLOT_FREE    = 2'd0,
    SLOT_ACTIVE  = 2'd1,
    SLOT_BLOCKED = 2'd2,
    SLOT_DEAD    = 2'd3
  } slot_state_t;

  typedef struct packed {
    logic        en;
    slot_state_t st;
  } slot_wr_t;

  typedef struct packed {
    logic [ID_FIELD_W-1:0] running;
    logic [ID_FIELD_W-1:0] created;
    status_t               status;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/rrts_slot_table.sv @@
// Thread slot table: per-slot state with reset, and joining waiter ids.
`default_nettype none

module rrts_slot_table #(
  parameter int MAX_THREADS = 16,
  parameter int IDX_W = 4,
  parameter int ID_W = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [IDX_W-1:0]     st_rd_idx,
  output rrts_pkg::slot_state_t     st_rd_data,
  input  wire rrts_pkg::slot_wr_t   st_wr,
  input  wire logic [IDX_W-1:0]     st_wr_idx,
  input  wire logic                 wt_we,
  input  wire logic [IDX_W-1:0]     wt_wr_idx,
  input  wire logic [ID_W-1:0]      wt_wr_data,
  input  wire logic [IDX_W-1:0]     wt_rd_idx,
  output logic [ID_W-1:0]           wt_rd_data
);

  rrts_pkg::slot_state_t slot_st_r [MAX_THREADS];
  logic [ID_W-1:0]       slot_wt_r [MAX_THREADS];
  logic [ID_W-1:0]       wt_rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_THREADS; i++) begin
        slot_st_r[i] <= rrts_pkg::SLOT_FREE;
      end
    end else if (st_wr.en) begin
      slot_st_r[st_wr_idx] <= st_wr.st;
    end
  end

  // The waiter read address is the running thread, which holds steady until a join or scan updates it.
  always_ff @(posedge clk) begin
    if (wt_we) begin
      slot_wt_r[wt_wr_idx] <= wt_wr_data;
    end
    wt_rd_data_r <= slot_wt_r[wt_rd_idx];
  end

  assign st_rd_data = slot_st_r[st_rd_idx];
  assign wt_rd_data = wt_rd_data_r;

endmodule

`default_nettype wire

@@ hdl/rrts_seq.sv @@
// Command sequencer with the shared round-robin slot scan unit.
`default_nettype none

module rrts_seq #(
  parameter int MAX_THREADS = 16,
  parameter int IDX_W = 4,
  parameter int ID_W = 5,
  parameter int NF_W = 5
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cmd_valid,
  output logic                                     cmd_ready,
  input  wire rrts_pkg::op_t                       cmd_op,
  input  wire logic [rrts_pkg::ID_FIELD_W-1:0]     cmd_tgt,
  output logic                                     res_valid,
  input  wire logic                                res_ready,
  output rrts_pkg::result_t                        res,
  output logic [IDX_W-1:0]                         st_rd_idx,
  input  wire rrts_pkg::slot_state_t               st_rd_data,
  output rrts_pkg::slot_wr_t                       st_wr,
  output logic [IDX_W-1:0]                         st_wr_idx,
  output logic                                     wt_we,
  output logic [IDX_W-1:0]                         wt_wr_idx,
  output logic [ID_W-1:0]                          wt_wr_data,
  output logic [IDX_W-1:0]                         wt_rd_idx,
  input  wire logic [ID_W-1:0]                     wt_rd_data
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CREATE = 8'b0000_0010,
    S_CHECK  = 8'b0000_0100,
    S_EXIT   = 8'b0000_1000,
    S_WAKE   = 8'b0001_0000,
    S_JOIN   = 8'b0010_0000,
    S_SCAN   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } seq_state_t;

  seq_state_t                          state_r, state_nxt;
  rrts_pkg::op_t                       op_r, op_nxt;
  logic [rrts_pkg::ID_FIELD_W-1:0]     tgt_r, tgt_nxt;
  logic [ID_W-1:0]                     cur_r, cur_nxt;
  logic [NF_W-1:0]                     nfree_r, nfree_nxt;
  logic                                started_r, started_nxt;
  logic [ID_W-1:0]                     sid_r, sid_nxt;
  logic [ID_W-1:0]                     cnt_r, cnt_nxt;
  logic [ID_W-1:0]                     w_r, w_nxt;
  logic [ID_W-1:0]                     created_r, created_nxt;
  rrts_pkg::status_t                   stat_r, stat_nxt;

  logic [ID_W-1:0] succ_in;
  logic [ID_W-1:0] succ;
  logic            cur_in_range;
  logic            w_in_range;
  logic            tgt_in_range;
  logic            nfree_in_range;
  logic            slot_used;

  assign succ_in = (state_r == S_SCAN) ? sid_r : cur_r;
  assign succ = (int'(succ_in) >= MAX_THREADS) ? ID_W'(1) : succ_in + ID_W'(1);

  assign cur_in_range = (cur_r != '0) && (int'(cur_r) <= MAX_THREADS);
  assign w_in_range = (w_r != '0) && (int'(w_r) <= MAX_THREADS);
  assign tgt_in_range = (tgt_r != '0) && (int'(tgt_r) <= MAX_THREADS);
  assign nfree_in_range = (nfree_r != '0) && (int'(nfree_r) <= MAX_THREADS);
  assign slot_used = (st_rd_data != rrts_pkg::SLOT_FREE);

  always_comb begin
    unique case (state_r)
      S_WAKE:  st_rd_idx = IDX_W'(w_r - ID_W'(1));
      S_JOIN:  st_rd_idx = IDX_W'(ID_W'(tgt_r) - ID_W'(1));
      S_SCAN:  st_rd_idx = IDX_W'(sid_r - ID_W'(1));
      default: st_rd_idx = IDX_W'(cur_r - ID_W'(1));
    endcase
  end

  assign wt_rd_idx = IDX_W'(cur_r - ID_W'(1));
  assign cmd_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res.running = rrts_pkg::ID_FIELD_W'(cur_r);
  assign res.created = rrts_pkg::ID_FIELD_W'(created_r);
  assign res.status = stat_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    tgt_nxt = tgt_r;
    cur_nxt = cur_r;
    nfree_nxt = nfree_r;
    started_nxt = started_r;
    sid_nxt = sid_r;
    cnt_nxt = cnt_r;
    w_nxt = w_r;
    created_nxt = created_r;
    stat_nxt = stat_r;
    st_wr = '{en: 1'b0, st: rrts_pkg::SLOT_FREE};
    st_wr_idx = IDX_W'(nfree_r - NF_W'(1));
    wt_we = 1'b0;
    wt_wr_idx = IDX_W'(nfree_r - NF_W'(1));
    wt_wr_data = '0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          op_nxt = cmd_op;
          tgt_nxt = cmd_tgt;
          created_nxt = '0;
          stat_nxt = rrts_pkg::STAT_OK;
          state_nxt = (cmd_op == rrts_pkg::OP_CREATE) ? S_CREATE : S_CHECK;
        end
      end
      S_CREATE: begin
        if (nfree_in_range) begin
          st_wr = '{en: 1'b1, st: rrts_pkg::SLOT_ACTIVE};
          wt_we = 1'b1;
          nfree_nxt = nfree_r + NF_W'(1);
          if (!started_r) begin
            started_nxt = 1'b1;
          end else begin
            created_nxt = ID_W'(nfree_r);
            state_nxt = S_DONE;
          end
        end else begin
          stat_nxt = rrts_pkg::STAT_FULL;
          state_nxt = S_DONE;
        end
      end
      S_CHECK: begin
        sid_nxt = succ;
        cnt_nxt = ID_W'(1);
        if (!(cur_in_range && slot_used)) begin
          stat_nxt = rrts_pkg::STAT_UNKNOWN;
          state_nxt = S_DONE;
        end else begin
          case (op_r)
            rrts_pkg::OP_YIELD: state_nxt = S_SCAN;
            rrts_pkg::OP_EXIT:  state_nxt = S_EXIT;
            default:            state_nxt = S_JOIN;
          endcase
        end
      end
      S_EXIT: begin
        st_wr = '{en: 1'b1, st: rrts_pkg::SLOT_DEAD};
        st_wr_idx = IDX_W'(cur_r - ID_W'(1));
        w_nxt = wt_rd_data;
        state_nxt = S_WAKE;
      end
      S_WAKE: begin
        if (w_in_range && slot_used) begin
          st_wr = '{en: 1'b1, st: rrts_pkg::SLOT_ACTIVE};
          st_wr_idx = IDX_W'(w_r - ID_W'(1));
        end
        state_nxt = S_SCAN;
      end
      S_JOIN: begin
        if (!(tgt_in_range && slot_used)) begin
          stat_nxt = rrts_pkg::STAT_UNKNOWN;
        end else if (st_rd_data == rrts_pkg::SLOT_ACTIVE) begin
          st_wr = '{en: 1'b1, st: rrts_pkg::SLOT_BLOCKED};
          st_wr_idx = IDX_W'(cur_r - ID_W'(1));
          wt_we = 1'b1;
          wt_wr_idx = IDX_W'(ID_W'(tgt_r) - ID_W'(1));
          wt_wr_data = cur_r;
          cur_nxt = ID_W'(tgt_r);
        end
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        if (st_rd_data == rrts_pkg::SLOT_ACTIVE) begin
          cur_nxt = sid_r;
          state_nxt = S_DONE;
        end else if (int'(cnt_r) >= MAX_THREADS) begin
          stat_nxt = rrts_pkg::STAT_NO_ACTIVE;
          if (op_r == rrts_pkg::OP_EXIT) begin
            cur_nxt = '0;
          end
          state_nxt = S_DONE;
        end else begin
          sid_nxt = succ;
          cnt_nxt = cnt_r + ID_W'(1);
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r <= ID_W'(1);
      nfree_r <= NF_W'(1);
      started_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r <= cur_nxt;
      nfree_r <= nfree_nxt;
      started_r <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    tgt_r <= tgt_nxt;
    sid_r <= sid_nxt;
    cnt_r <= cnt_nxt;
    w_r <= w_nxt;
    created_r <= created_nxt;
    stat_r <= stat_nxt;
  end

endmodule

`default_nettype wire

@@ hdl/round_robin_thread_scheduler.sv @@
// Round-robin thread scheduler with join: top level with result register.
//
//   Channel  Direction  Payload
//   in_      slave      op, target_thread
//   out_     master     running_thread, created_thread, status
//
// Yield and exit run a scan that reads one slot per cycle to find the next
// active thread. The input is not ready while a command is in progress.
// A result waiting in the output register does not stop the next transfer.
// Reset is synchronous; all slots become free in the reset cycle.
`default_nettype none

module round_robin_thread_scheduler #(
  parameter int MAX_THREADS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [rrts_pkg::IN_TDATA_W-1:0]      in_tdata,   // op, target_thread
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [rrts_pkg::OUT_TDATA_W-1:0]          out_tdata   // running, created, status
);

  localparam int ID_W = $clog2(MAX_THREADS + 1);
  localparam int IDX_W = $clog2(MAX_THREADS);
  localparam int NF_W = $clog2(MAX_THREADS + 2);

  logic                    res_valid;
  logic                    res_ready;
  rrts_pkg::result_t       res;
  logic                    out_valid_r;
  rrts_pkg::result_t       out_res_r;
  logic [IDX_W-1:0]        st_rd_idx;
  rrts_pkg::slot_state_t   st_rd_data;
  rrts_pkg::slot_wr_t      st_wr;
  logic [IDX_W-1:0]        st_wr_idx;
  logic                    wt_we;
  logic [IDX_W-1:0]        wt_wr_idx;
  logic [ID_W-1:0]         wt_wr_data;
  logic [IDX_W-1:0]        wt_rd_idx;
  logic [ID_W-1:0]         wt_rd_data;

  rrts_seq #(
    .MAX_THREADS(MAX_THREADS),
    .IDX_W(IDX_W),
    .ID_W(ID_W),
    .NF_W(NF_W)
  ) u_seq (
    .clk(clk),
    .rst_n(rst_n),
    .cmd_valid(in_tvalid),
    .cmd_ready(in_tready),
    .cmd_op(rrts_pkg::op_t'(in_tdata[1:0])),
    .cmd_tgt(in_tdata[6:2]),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res),
    .st_rd_idx(st_rd_idx),
    .st_rd_data(st_rd_data),
    .st_wr(st_wr),
    .st_wr_idx(st_wr_idx),
    .wt_we(wt_we),
    .wt_wr_idx(wt_wr_idx),
    .wt_wr_data(wt_wr_data),
    .wt_rd_idx(wt_rd_idx),
    .wt_rd_data(wt_rd_data)
  );

  rrts_slot_table #(
    .MAX_THREADS(MAX_THREADS),
    .IDX_W(IDX_W),
    .ID_W(ID_W)
  ) u_table (
    .clk(clk),
    .rst_n(rst_n),
    .st_rd_idx(st_rd_idx),
    .st_rd_data(st_rd_data),
    .st_wr(st_wr),
    .st_wr_idx(st_wr_idx),
    .wt_we(wt_we),
    .wt_wr_idx(wt_wr_idx),
    .wt_wr_data(wt_wr_data),
    .wt_rd_idx(wt_rd_idx),
    .wt_rd_data(wt_rd_data)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {4'b0000, out_res_r.status, out_res_r.created, out_res_r.running};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a command transfer");

  a_full_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_res_r.status == rrts_pkg::STAT_FULL) |-> (out_res_r.created == '0))
    else $error("failed create reports an id");

  a_created_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_res_r.created != '0) |-> (out_res_r.status == rrts_pkg::STAT_OK))
    else $error("created id with a non-ok status");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_res_r))
    else $error("result changed while stalled");

endmodule

`default_nettype wire
